// ----- sv/oar_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the orientation align/rotate block.
// No dependencies; imported by oar_rotator and orientation_align_rotate.
package oar_pkg;

    localparam int MAX_ORIENTATIONS = 8;
    localparam int LANES            = 8;
    localparam int VAL_W            = 16;
    localparam int IDX_W            = 3;
    localparam int CNT_W            = 4;
    localparam int DATA_W           = 136;
    localparam int PAD_W            = DATA_W - IDX_W - LANES * VAL_W;
    localparam int LIM_CNT          = (MAX_ORIENTATIONS < LANES) ? MAX_ORIENTATIONS : LANES;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef t_val [LANES-1:0]        t_vals;

    typedef enum logic {
        REQ_ALIGN   = 1'b0,
        REQ_UNALIGN = 1'b1
    } t_req_type;

    // argmax candidate
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        t_val             val;
        logic             ok;
    } t_cand;

endpackage

// ----- sv/oar_rotator.sv -----
`timescale 1ns / 1ps
// Circular lane rotator: moves values by a direction modulo the active count i_cnt; lanes past it read zero.
// Depends on oar_pkg.
module oar_rotator
    import oar_pkg::*;
(
    input  t_vals            i_vals,
    input  logic [IDX_W-1:0] i_dir,
    input  logic [CNT_W-1:0] i_cnt,
    input  t_req_type        i_mode,
    output t_vals            o_vals
);

    function automatic logic [IDX_W-1:0] rot_src(
        input logic [CNT_W-1:0] k,
        input logic [IDX_W-1:0] d,
        input logic [CNT_W-1:0] cnt,
        input t_req_type        mode
    );
        logic [CNT_W-1:0] s;
        if (mode == REQ_UNALIGN) begin
            s = k + cnt - {1'b0, d};
        end else begin
            s = k + {1'b0, d};
        end
        if (s >= cnt) begin
            s = s - cnt;
        end
        return s[IDX_W-1:0];
    endfunction

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            if (CNT_W'(k) < i_cnt) begin
                o_vals[k] = i_vals[rot_src(CNT_W'(k), i_dir, i_cnt, i_mode)];
            end else begin
                o_vals[k] = '0;
            end
        end
    end

endmodule

// ----- sv/orientation_align_rotate.sv -----
`timescale 1ns / 1ps
// Top level: four-stage pipeline for orientation align / unalign.
// Depends on oar_pkg and oar_rotator.
//
//  channel   dir  signals                               beat content
//  --------  ---  ------------------------------------  ---------------------------------
//  s_axis    in   s_axis_tvalid/tready/tdata/tuser      one feature's orientation values
//  m_axis    out  m_axis_tvalid/tready/tdata            direction and rotated values
//  cfg       in   i_cfg_we/i_cfg_wdata                  num_orientations
//
// One beat per cycle sustained while m_axis_tready stays high. Stage 1 does the first
// compare level and the direction reduction, stage 2 and 3 the remaining
// compare levels, stage 4 the rotation mux into the output register.
// Synchronous active-low reset clears valids and sets num_orientations to 8.
// A stage advances when the stage after it is empty or advancing; a stall
// holds each full stage with no empty stage after it, while empty stages still fill.
module orientation_align_rotate
    import oar_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [2:0] direction_in, [18:3] v0 ... [130:115] v7, [135:131] zero
    input  logic [DATA_W-1:0] s_axis_tdata,
    // [0] req_type
    input  logic              s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [2:0] direction_out, [18:3] r0 ... [130:115] r7, [135:131] zero
    output logic [DATA_W-1:0] m_axis_tdata
);

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        r = c;
        if (r == '0) begin
            r = CNT_W'(1);
        end
        if (r > CNT_W'(LIM_CNT)) begin
            r = CNT_W'(LIM_CNT);
        end
        return r;
    endfunction

    // d < 8 and cnt in 1..8: counts of 3 and up need at most two subtractions
    function automatic logic [IDX_W-1:0] mod_dir(
        input logic [IDX_W-1:0] d,
        input logic [CNT_W-1:0] cnt
    );
        logic [CNT_W-1:0] r;
        r = {1'b0, d};
        if (cnt == CNT_W'(1)) begin
            r = '0;
        end else if (cnt == CNT_W'(2)) begin
            r = CNT_W'(d[0]);
        end else begin
            if (r >= cnt) begin
                r = r - cnt;
            end
            if (r >= cnt) begin
                r = r - cnt;
            end
        end
        return r[IDX_W-1:0];
    endfunction

    // lower index stays in a, so ties keep the first maximum
    function automatic t_cand pick(input t_cand a, input t_cand b);
        if (b.ok && (!a.ok || ($signed(b.val) > $signed(a.val)))) begin
            return b;
        end
        return a;
    endfunction

    logic [CNT_W-1:0] r_num_orient;

    logic             r_s1_vld, r_s2_vld, r_s3_vld, r_out_vld;
    logic             en1, en2, en3, en4;

    t_req_type        r_s1_mode, r_s2_mode, r_s3_mode;
    logic [IDX_W-1:0] r_s1_dir, r_s2_dir, r_s3_dir, r_out_dir;
    logic [CNT_W-1:0] r_s1_cnt, r_s2_cnt, r_s3_cnt;
    t_vals            r_s1_v, r_s2_v, r_s3_v, r_out_r;
    t_cand [3:0]      r_s1_c;
    t_cand [1:0]      r_s2_c;

    t_vals            n_in_v;
    logic [CNT_W-1:0] n_cnt;
    t_cand [LANES-1:0] n_lane_c;
    t_cand [3:0]      n_s1_c;
    t_cand [1:0]      n_s2_c;
    t_cand            n_s3_c;
    t_vals            n_out_r;

    assign en4 = !r_out_vld || m_axis_tready;
    assign en3 = !r_s3_vld || en4;
    assign en2 = !r_s2_vld || en3;
    assign en1 = !r_s1_vld || en2;
    assign s_axis_tready = en1;

    assign n_cnt = eff_count(r_num_orient);

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            n_in_v[k]       = s_axis_tdata[IDX_W + k*VAL_W +: VAL_W];
            n_lane_c[k].idx = IDX_W'(k);
            n_lane_c[k].val = n_in_v[k];
            n_lane_c[k].ok  = CNT_W'(k) < n_cnt;
        end
        for (int j = 0; j < 4; j++) begin
            n_s1_c[j] = pick(n_lane_c[2*j], n_lane_c[2*j+1]);
        end
        for (int j = 0; j < 2; j++) begin
            n_s2_c[j] = pick(r_s1_c[2*j], r_s1_c[2*j+1]);
        end
        n_s3_c = pick(r_s2_c[0], r_s2_c[1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_orient <= CNT_W'(8);
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_s3_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_orient <= i_cfg_wdata;
            end
            if (en1) r_s1_vld  <= s_axis_tvalid;
            if (en2) r_s2_vld  <= r_s1_vld;
            if (en3) r_s3_vld  <= r_s2_vld;
            if (en4) r_out_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_mode <= t_req_type'(s_axis_tuser);
            r_s1_dir  <= mod_dir(s_axis_tdata[IDX_W-1:0], n_cnt);
            r_s1_cnt  <= n_cnt;
            r_s1_v    <= n_in_v;
            r_s1_c    <= n_s1_c;
        end
        if (en2) begin
            r_s2_mode <= r_s1_mode;
            r_s2_dir  <= r_s1_dir;
            r_s2_cnt  <= r_s1_cnt;
            r_s2_v    <= r_s1_v;
            r_s2_c    <= n_s2_c;
        end
        if (en3) begin
            r_s3_mode <= r_s2_mode;
            r_s3_dir  <= (r_s2_mode == REQ_ALIGN) ? n_s3_c.idx : r_s2_dir;
            r_s3_cnt  <= r_s2_cnt;
            r_s3_v    <= r_s2_v;
        end
        if (en4) begin
            r_out_dir <= r_s3_dir;
            r_out_r   <= n_out_r;
        end
    end

    oar_rotator u_rot (
        .i_vals (r_s3_v),
        .i_dir  (r_s3_dir),
        .i_cnt  (r_s3_cnt),
        .i_mode (r_s3_mode),
        .o_vals (n_out_r)
    );

    assign m_axis_tvalid = r_out_vld;

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[IDX_W-1:0] = r_out_dir;
        for (int k = 0; k < LANES; k++) begin
            m_axis_tdata[IDX_W + k*VAL_W +: VAL_W] = r_out_r[k];
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for orientation_align_rotate: streams feature beats, predicts the aligned or
// unaligned rotation of each one and checks every output beat field by field.
// Depends on oar_pkg and the orientation_align_rotate RTL.
module tb_top;
    import oar_pkg::*;

    localparam int PIPE_LAT   = 4;
    localparam int WDOG_LIMIT = 2000;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wdata   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;
    logic              s_axis_tuser  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;

    logic [DATA_W-1:0] pending_rotations [$];
    logic [CNT_W-1:0]  orient_cnt_reg = CNT_W'(8);
    int                err_count      = 0;
    int                beats_in       = 0;
    int                beats_out      = 0;
    int                cnt_writes     = 0;
    int                idle_cycles    = 0;
    int                hold_request   = 0;
    bit                src_gaps_en    = 1'b1;
    bit                sink_stall_en  = 1'b1;

    orientation_align_rotate DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // expected output beat for one feature under the current orientation count
    function automatic logic [DATA_W-1:0] rotate_feature(t_req_type req, logic [IDX_W-1:0] dir,
                                                         t_vals vals, logic [CNT_W-1:0] cnt);
        int                n;
        int                d;
        int                src;
        t_val              best;
        logic [DATA_W-1:0] res;
        n = int'(cnt);
        if (n == 0) n = 1;
        if (n > LIM_CNT) n = LIM_CNT;
        if (req == REQ_ALIGN) begin
            d = 0;
            best = vals[0];
            for (int k = 1; k < n; k++) begin
                if ($signed(vals[k]) > $signed(best)) begin
                    best = vals[k];
                    d = k;
                end
            end
        end else begin
            d = int'(dir) % n;
        end
        res = '0;
        res[IDX_W-1:0] = IDX_W'(d);
        for (int k = 0; k < n; k++) begin
            src = (req == REQ_ALIGN) ? (k + d) % n : (k + n - d) % n;
            res[IDX_W + k*VAL_W +: VAL_W] = vals[src];
        end
        return res;
    endfunction

    function automatic t_vals lanes8(int a0, int a1, int a2, int a3,
                                     int a4, int a5, int a6, int a7);
        t_vals v;
        v[0] = t_val'(a0); v[1] = t_val'(a1); v[2] = t_val'(a2); v[3] = t_val'(a3);
        v[4] = t_val'(a4); v[5] = t_val'(a5); v[6] = t_val'(a6); v[7] = t_val'(a7);
        return v;
    endfunction

    // mix of full-range, corner and tie-prone values
    function automatic t_val orient_value(int style);
        t_val corners [5];
        corners = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
        case (style)
            0:       return t_val'($urandom_range(0, 65535));
            1:       return corners[$urandom_range(0, 4)];
            default: return t_val'($urandom_range(0, 3)) - t_val'(1);
        endcase
    endfunction

    task automatic flag_error(string msg);
        $display("ERROR: %s", msg);
        err_count++;
    endtask

    task automatic stream_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_feature(t_req_type req, logic [IDX_W-1:0] dir, t_vals vals);
        int gap;
        gap = (src_gaps_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 11) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {{PAD_W{1'b0}}, vals, dir};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_rotations.push_back(rotate_feature(req, dir, vals, orient_cnt_reg));
        beats_in++;
    endtask

    task automatic send_random_feature();
        t_vals v;
        int    style;
        style = $urandom_range(0, 2);
        for (int k = 0; k < LANES; k++) v[k] = orient_value(style);
        send_feature(t_req_type'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 7)), v);
    endtask

    // wait for every expected beat, then let the pipe settle
    task automatic drain_results();
        stream_idle();
        while (pending_rotations.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    task automatic write_orient_cnt(logic [CNT_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        orient_cnt_reg = value;
        cnt_writes++;
    endtask

    task automatic test_reset_count();
        send_feature(REQ_ALIGN,   3'd0, lanes8(1, 2, 3, 4, 5, 6, 7, 300));
        send_feature(REQ_ALIGN,   3'd5, lanes8(32767, 0, -1, 5, 6, 7, 8, 9));
        send_feature(REQ_ALIGN,   3'd0, lanes8(77, 77, 77, 77, 77, 77, 77, 77));
        send_feature(REQ_ALIGN,   3'd0, lanes8(-5, 0, 32767, 1, 2, 32767, 3, 4));
        send_feature(REQ_ALIGN,   3'd0, lanes8(-32768, -32768, -32768, -32768,
                                               -32768, -32768, -32768, -32768));
        send_feature(REQ_ALIGN,   3'd7, lanes8(-32768, -1, 0, -2, -32767, -3, 1, -4));
        send_feature(REQ_UNALIGN, 3'd0, lanes8(10, 11, 12, 13, 14, 15, 16, 17));
        send_feature(REQ_UNALIGN, 3'd7, lanes8(-32768, 32767, -1, 0, 1, 2, 3, 4));
        send_feature(REQ_UNALIGN, 3'd3, lanes8(21, 22, 23, 24, 25, 26, 27, 28));
    endtask

    task automatic test_count_limits();
        write_orient_cnt(CNT_W'(0));
        send_feature(REQ_ALIGN,   3'd0, lanes8(-9, 100, 200, 300, 400, 500, 600, 700));
        send_feature(REQ_UNALIGN, 3'd7, lanes8(42, 1, 2, 3, 4, 5, 6, 7));
        write_orient_cnt(CNT_W'(15));
        send_feature(REQ_ALIGN,   3'd0, lanes8(0, 1, 2, 3, 4, 5, 6, 32767));
        send_feature(REQ_UNALIGN, 3'd5, lanes8(1, 2, 3, 4, 5, 6, 7, 8));
        // values past the count are ignored, lanes past it read zero
        write_orient_cnt(CNT_W'(3));
        send_feature(REQ_ALIGN,   3'd0, lanes8(5, 9, 2, 32767, 100, 32767, -1, 7));
        send_feature(REQ_UNALIGN, 3'd7, lanes8(-100, 200, -300, 400, -500, 600, -700, 800));
        send_feature(REQ_UNALIGN, 3'd6, lanes8(1, 2, 3, 4, 5, 6, 7, 8));
        send_feature(REQ_ALIGN,   3'd0, lanes8(4, 4, 4, 9, 9, 9, 9, 9));
    endtask

    task automatic test_random_counts();
        int cnt_plan [11];
        cnt_plan = '{1, 2, 3, 4, 5, 6, 7, 8, 0, 15, 9};
        foreach (cnt_plan[i]) begin
            write_orient_cnt(CNT_W'(cnt_plan[i]));
            repeat (40) send_random_feature();
        end
        write_orient_cnt(CNT_W'($urandom_range(0, 15)));
        repeat (40) send_random_feature();
    endtask

    task automatic test_output_backpressure();
        write_orient_cnt(CNT_W'($urandom_range(2, 8)));
        src_gaps_en = 1'b0;
        @(posedge i_clk);
        hold_request = 60;
        repeat (40) send_random_feature();
        src_gaps_en = 1'b1;
        repeat (20) send_random_feature();
    endtask

    task automatic test_sender_pause();
        repeat (30) send_random_feature();
        drain_results();
        repeat (30) send_random_feature();
    endtask

    task automatic test_steady_stream();
        write_orient_cnt(CNT_W'(8));
        src_gaps_en   = 1'b0;
        sink_stall_en = 1'b0;
        repeat (120) send_random_feature();
    endtask

    // output side ready: random stall bursts and a long hold on request
    always @(negedge i_clk) begin
        static int hold_left  = 0;
        static int stall_left = 0;
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(0, 10);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        logic [DATA_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            if (pending_rotations.size() == 0) begin
                flag_error($sformatf("output beat %0d with nothing expected", beats_out));
            end else begin
                want = pending_rotations.pop_front();
                if (m_axis_tdata[IDX_W-1:0] !== want[IDX_W-1:0])
                    flag_error($sformatf("beat %0d direction_out: expected %0d got %0d",
                                         beats_out, want[IDX_W-1:0], m_axis_tdata[IDX_W-1:0]));
                for (int k = 0; k < LANES; k++) begin
                    if (m_axis_tdata[IDX_W + k*VAL_W +: VAL_W] !== want[IDX_W + k*VAL_W +: VAL_W])
                        flag_error($sformatf("beat %0d r%0d: expected %h got %h", beats_out, k,
                                             want[IDX_W + k*VAL_W +: VAL_W],
                                             m_axis_tdata[IDX_W + k*VAL_W +: VAL_W]));
                end
                if (m_axis_tdata[DATA_W-1 -: PAD_W] !== '0)
                    flag_error($sformatf("beat %0d pad bits not zero: %h",
                                         beats_out, m_axis_tdata[DATA_W-1 -: PAD_W]));
            end
        end
    end

    // watchdog on cycles without any beat or register write
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("Timeout after %0d idle cycles", idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_count();
        test_count_limits();
        test_random_counts();
        test_output_backpressure();
        test_sender_pause();
        test_steady_stream();
        drain_results();
        if (pending_rotations.size() != 0)
            flag_error($sformatf("%0d expected beats never arrived", pending_rotations.size()));
        $display("Run covered %0d input and %0d output beats, align and unalign, %0d count writes",
                 beats_in, beats_out, cnt_writes);
        $display("including counts 0, 1, 8 and 15, ties, lane extremes and output backpressure");
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/oar_pkg.sv
sv/oar_rotator.sv
sv/orientation_align_rotate.sv
tb/sv/tb_top.sv
